FILE: rtl/spdif_pkg.sv
// Shared constants, types and channel status functions for the S/PDIF subframe encoder.
package spdif_pkg;

  localparam int unsigned BlockFrames = 192;
  localparam int unsigned PosW        = 8;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned SubframeW   = 32;
  localparam int unsigned RateW       = 18;

  localparam logic [PosW-1:0]  LastPos     = PosW'(BlockFrames - 1);
  localparam logic [RateW-1:0] RateReset   = RateW'(48000);

  localparam logic [3:0] PreBlockStart = 4'h8;
  localparam logic [3:0] PreLeft       = 4'h2;
  localparam logic [3:0] PreRight      = 4'h4;

  localparam logic [7:0] CsByte0      = 8'h04;
  localparam logic [7:0] CsByte1      = 8'h00;
  localparam logic [7:0] CsByte2Left  = 8'h10;
  localparam logic [7:0] CsByte2Right = 8'h20;
  localparam logic [7:0] CsByte4      = 8'h02;
  localparam logic [7:0] CsByteRest   = 8'h00;

  localparam logic [4:0] ByteCat     = 5'd0;
  localparam logic [4:0] ByteMode    = 5'd1;
  localparam logic [4:0] ByteChannel = 5'd2;
  localparam logic [4:0] ByteRate    = 5'd3;
  localparam logic [4:0] ByteWord    = 5'd4;

  typedef struct packed {
    logic       cs_lft;
    logic       cs_rgt;
    logic [3:0] pre_left;
  } spdif_cs_t;

  function automatic logic [7:0] rate_code(input logic [RateW-1:0] hz);
    logic [7:0] code;
    unique case (hz)
      RateW'(22050):  code = 8'h04;
      RateW'(44100):  code = 8'h00;
      RateW'(88200):  code = 8'h08;
      RateW'(176400): code = 8'h0C;
      RateW'(24000):  code = 8'h06;
      RateW'(48000):  code = 8'h02;
      RateW'(96000):  code = 8'h0A;
      RateW'(192000): code = 8'h0E;
      RateW'(32000):  code = 8'h03;
      RateW'(8000):   code = 8'h06;
      RateW'(11025):  code = 8'h00;
      RateW'(12000):  code = 8'h02;
      RateW'(16000):  code = 8'h03;
      default:        code = 8'h02;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] status_byte(input logic [4:0] idx, input logic right,
                                             input logic [7:0] rcode);
    logic [7:0] b;
    unique case (idx)
      ByteCat:     b = CsByte0;
      ByteMode:    b = CsByte1;
      ByteChannel: b = right ? CsByte2Right : CsByte2Left;
      ByteRate:    b = rcode;
      ByteWord:    b = CsByte4;
      default:     b = CsByteRest;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/spdif_if.sv
// Valid/ready channel interfaces for stereo frames and encoded subframe pairs.
interface spdif_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source(output valid, output left_sample, output right_sample, input ready);
  modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

interface spdif_subframe_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_subframe;
  logic [31:0] right_subframe;

  modport source(output valid, output left_subframe, output right_subframe, input ready);
  modport sink(input valid, input left_subframe, input right_subframe, output ready);
endinterface

FILE: rtl/spdif_cs_gen.sv
// Sample rate register, block frame counter and channel status bit selection.
module spdif_cs_gen
  import spdif_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RateW-1:0]    cfg_wdata_i,
  input  logic                advance_i,
  output spdif_cs_t           cs_o
);

  logic [RateW-1:0] sample_rate_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       rcode;
  logic [7:0]       byte_l, byte_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= RateReset;
      pos_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        sample_rate_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (advance_i) begin
      pos_d = (pos_q >= LastPos) ? '0 : pos_q + 1'b1;
    end
  end

  assign rcode  = rate_code(sample_rate_q);
  assign byte_l = status_byte(pos_q[7:3], 1'b0, rcode);
  assign byte_r = status_byte(pos_q[7:3], 1'b1, rcode);

  assign cs_o.cs_lft   = byte_l[pos_q[2:0]];
  assign cs_o.cs_rgt   = byte_r[pos_q[2:0]];
  assign cs_o.pre_left = (pos_q == '0) ? PreBlockStart : PreLeft;

  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos) else $error("frame position beyond block end");

  a_pos_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && pos_q == LastPos) |=> pos_q == '0)
    else $error("frame position failed to wrap");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(pos_q)) else $error("frame position moved without a beat");

endmodule

FILE: rtl/spdif_pack.sv
// Assembles one subframe word from sample, status bit and preamble, with even parity.
module spdif_pack
  import spdif_pkg::*;
(
  input  logic [SampleW-1:0]   sample_i,
  input  logic                 cs_i,
  input  logic [3:0]           pre_i,
  output logic [SubframeW-1:0] subframe_o
);

  logic parity;

  assign parity     = cs_i ^ (^sample_i);
  assign subframe_o = {parity, cs_i, 2'b00, sample_i, 8'h00, pre_i};

endmodule

FILE: rtl/spdif_subframe_encoder.sv
// Top level of the S/PDIF subframe encoder: input register, encoder and result register.
//
//   Channel     Dir  Handshake     Payload
//   frame_i     in   valid/ready   left_sample, right_sample (signed 16 bit)
//   subframe_o  out  valid/ready   left_subframe, right_subframe (32 bit)
//   cfg         in   cfg_we_i      cfg_wdata_i: sample rate in hertz (18 bit)
//
// One frame is taken per cycle while ready is high, then passes to the result register.
// The input register and the result register each advance when the stage after
// them is empty or being emptied, so a stalled sink fills both before ready falls.
// Reset clears the valid flags, sets the frame counter to zero and the rate to 48 kHz.
module spdif_subframe_encoder
  import spdif_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RateW-1:0]      cfg_wdata_i,
  spdif_frame_if.sink           frame_i,
  spdif_subframe_if.source      subframe_o
);

  logic                       in_valid_q;
  logic signed [SampleW-1:0]  left_q, right_q;
  logic                       out_valid_q;
  logic [SubframeW-1:0]       left_sf_q, right_sf_q;
  logic [SubframeW-1:0]       left_sf_d, right_sf_d;
  logic                       out_ready, in_ready, advance;
  spdif_cs_t                  cs;

  assign out_ready = !out_valid_q || subframe_o.ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign advance   = in_valid_q && out_ready;

  assign frame_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= frame_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && in_ready) begin
      left_q  <= frame_i.left_sample;
      right_q <= frame_i.right_sample;
    end
    if (advance) begin
      left_sf_q  <= left_sf_d;
      right_sf_q <= right_sf_d;
    end
  end

  spdif_cs_gen u_cs_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .cs_o        (cs)
  );

  spdif_pack u_pack_left (
    .sample_i   (left_q),
    .cs_i       (cs.cs_lft),
    .pre_i      (cs.pre_left),
    .subframe_o (left_sf_d)
  );

  spdif_pack u_pack_right (
    .sample_i   (right_q),
    .cs_i       (cs.cs_rgt),
    .pre_i      (PreRight),
    .subframe_o (right_sf_d)
  );

  assign subframe_o.valid          = out_valid_q;
  assign subframe_o.left_subframe  = left_sf_q;
  assign subframe_o.right_subframe = right_sf_q;

  a_left_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (left_sf_q[3:0] == PreBlockStart || left_sf_q[3:0] == PreLeft))
    else $error("left subframe carries a bad preamble");

  a_even_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (^left_sf_q[31:4] == 1'b0 && ^right_sf_q[31:4] == 1'b0))
    else $error("subframe parity is odd");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !subframe_o.ready) |=>
      (out_valid_q && $stable(left_sf_q) && $stable(right_sf_q)))
    else $error("waiting result overwritten");

endmodule

FILE: bench/tb_spdif_subframe_encoder.sv
// Self-checking testbench for the S/PDIF subframe encoder: directed and random frames checked against a built-in predictor.
module tb_spdif_subframe_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import spdif_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PrintLimit    = 100;

  typedef struct packed {
    logic [SubframeW-1:0] left;
    logic [SubframeW-1:0] right;
  } subframe_pair_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [RateW-1:0] cfg_wdata_i;

  spdif_frame_if    frame_ch();
  spdif_subframe_if subframe_ch();

  spdif_subframe_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_ch),
    .subframe_o  (subframe_ch)
  );

  subframe_pair_t   expected_pairs[$];
  subframe_pair_t   due_pair;
  logic [PosW-1:0]  frame_pos;
  logic [RateW-1:0] sample_rate_q;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      error_count;
  int unsigned      stall_cycles;
  int unsigned      frames_sent;
  int unsigned      results_checked;
  int unsigned      rate_writes;
  int unsigned      block_wraps;

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] expected_rate_code(input logic [RateW-1:0] hz);
    logic [7:0] code;
    case (hz)
      RateW'(22050):  code = 8'h04;
      RateW'(44100):  code = 8'h00;
      RateW'(88200):  code = 8'h08;
      RateW'(176400): code = 8'h0C;
      RateW'(24000):  code = 8'h06;
      RateW'(48000):  code = 8'h02;
      RateW'(96000):  code = 8'h0A;
      RateW'(192000): code = 8'h0E;
      RateW'(32000):  code = 8'h03;
      RateW'(8000):   code = 8'h06;
      RateW'(11025):  code = 8'h00;
      RateW'(12000):  code = 8'h02;
      RateW'(16000):  code = 8'h03;
      default:        code = 8'h02;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] expected_status_byte(input logic [4:0] idx, input logic right);
    logic [7:0] b;
    case (idx)
      ByteCat:     b = CsByte0;
      ByteMode:    b = CsByte1;
      ByteChannel: b = right ? CsByte2Right : CsByte2Left;
      ByteRate:    b = expected_rate_code(sample_rate_q);
      ByteWord:    b = CsByte4;
      default:     b = CsByteRest;
    endcase
    return b;
  endfunction

  function automatic logic [SubframeW-1:0] build_subframe(input logic [SampleW-1:0] sample,
                                                          input logic cs, input logic [3:0] pre);
    logic [SubframeW-1:0] word;
    word = {1'b0, cs, 2'b00, sample, 8'h00, pre};
    word[31] = ^word[30:4];
    return word;
  endfunction

  function automatic logic [SampleW-1:0] random_sample();
    logic [SampleW-1:0] s;
    case ($urandom_range(9))
      0:       s = 16'h7FFF;
      1:       s = 16'h8000;
      2:       s = 16'h0000;
      3:       s = 16'hFFFF;
      default: s = SampleW'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [RateW-1:0] pick_rate();
    logic [RateW-1:0] hz;
    case ($urandom_range(19))
      0:       hz = '0;
      1:       hz = RateW'(192000);
      4:       hz = RateW'(22050);
      5:       hz = RateW'(44100);
      6:       hz = RateW'(88200);
      7:       hz = RateW'(176400);
      8:       hz = RateW'(24000);
      9:       hz = RateW'(48000);
      10:      hz = RateW'(96000);
      11:      hz = RateW'(192000);
      12:      hz = RateW'(32000);
      13:      hz = RateW'(8000);
      14:      hz = RateW'(11025);
      15:      hz = RateW'(12000);
      16:      hz = RateW'(16000);
      default: hz = RateW'($urandom_range(192000));
    endcase
    return hz;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic send_frame(input logic [SampleW-1:0] left, input logic [SampleW-1:0] right);
    logic [7:0]     left_byte;
    logic [7:0]     right_byte;
    subframe_pair_t pair;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    frame_ch.valid        <= 1'b1;
    frame_ch.left_sample  <= left;
    frame_ch.right_sample <= right;
    @(posedge clk_i);
    while (!frame_ch.ready) begin
      @(posedge clk_i);
    end
    left_byte  = expected_status_byte(frame_pos[7:3], 1'b0);
    right_byte = expected_status_byte(frame_pos[7:3], 1'b1);
    pair.left  = build_subframe(left, left_byte[frame_pos[2:0]],
                                (frame_pos == '0) ? PreBlockStart : PreLeft);
    pair.right = build_subframe(right, right_byte[frame_pos[2:0]], PreRight);
    expected_pairs.push_back(pair);
    if (frame_pos == LastPos) begin
      frame_pos = '0;
      block_wraps++;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    frames_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    frame_ch.valid <= 1'b0;
    wait (expected_pairs.size() == 0);
  endtask

  task automatic write_rate(input logic [RateW-1:0] hz);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sample_rate_q = hz;
    rate_writes++;
  endtask

  task automatic test_sample_extremes();
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555);
    send_frame(16'h0001, 16'hFFFE);
    send_frame(16'h8001, 16'h7FFE);
  endtask

  // The rate changes halfway through the rate byte, and the second rate is not in the table.
  task automatic test_rate_extremes();
    write_rate(RateW'(192000));
    while (frame_pos != PosW'(28)) begin
      send_frame(random_sample(), random_sample());
    end
    write_rate('0);
    while (frame_pos != PosW'(32)) begin
      send_frame(random_sample(), random_sample());
    end
  endtask

  task automatic test_random_traffic(input int unsigned frames, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < frames) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
      end else begin
        write_rate(pick_rate());
      end
      run_len = $urandom_range(60, 1);
      for (k = 0; k < run_len && sent < frames; k++) begin
        send_frame(random_sample(), random_sample());
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      subframe_ch.ready <= 1'b0;
    end else begin
      subframe_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && subframe_ch.valid && subframe_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: left %08h right %08h",
                                  subframe_ch.left_subframe, subframe_ch.right_subframe));
      end else begin
        due_pair = expected_pairs.pop_front();
        results_checked++;
        if (subframe_ch.left_subframe !== due_pair.left) begin
          report_mismatch($sformatf("left subframe %08h, expected %08h",
                                    subframe_ch.left_subframe, due_pair.left));
        end
        if (subframe_ch.right_subframe !== due_pair.right) begin
          report_mismatch($sformatf("right subframe %08h, expected %08h",
                                    subframe_ch.right_subframe, due_pair.right));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (frame_ch.valid && frame_ch.ready) ||
        (subframe_ch.valid && subframe_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding.",
               stall_cycles, expected_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    frame_ch.valid        = 1'b0;
    frame_ch.left_sample  = '0;
    frame_ch.right_sample = '0;
    subframe_ch.ready     = 1'b0;
    frame_pos             = '0;
    sample_rate_q         = RateReset;
    send_idle_pct         = 34;
    recv_idle_pct         = 55;
    error_count           = 0;
    stall_cycles          = 0;
    frames_sent           = 0;
    results_checked       = 0;
    rate_writes           = 0;
    block_wraps           = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sample_extremes();
    test_rate_extremes();
    test_random_traffic(173, 34, 55);
    test_random_traffic(173, 55, 34);
    test_random_traffic(173, 0, 0);

    drain_results();
    repeat (6) @(posedge clk_i);
    $display("Run covered %0d frames across %0d block wraps with %0d sample-rate writes.",
             frames_sent, block_wraps, rate_writes);
    $display("%0d subframe pairs checked, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spdif_pkg.sv
rtl/spdif_if.sv
rtl/spdif_cs_gen.sv
rtl/spdif_pack.sv
rtl/spdif_subframe_encoder.sv
bench/tb_spdif_subframe_encoder.sv
